>>> design/aff_pkg.sv
// Shared types and constants of the affine grid resampler.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps

package aff_pkg;

    localparam int MAX_SIDE_DEF = 128;

    // Field and datapath widths. Counts are 8 bits, so a clamped corner
    // index never exceeds 254; coordinates are sized for the largest grid.
    localparam int SMP_W = 16;
    localparam int POS_W = 7;
    localparam int CNT_W = 8;
    localparam int IDX_W = 8;
    localparam int DC_W  = 10;
    localparam int MUL_W = 42;
    localparam int ACC_W = 44;
    localparam int CRD_W = 29;
    localparam int SQ_W  = 2 * CRD_W;
    localparam int D_W   = SQ_W + 1;
    localparam int W_W   = 37;
    localparam int PRD_W = W_W + 1 + SMP_W;
    localparam int NUM_W = 56;
    localparam int DEN_W = 39;
    localparam int DIV_W = 64;
    localparam int REG_W = 32;
    localparam int RIX_W = 3;

    localparam int WGT_STEPS = 37;
    localparam int MEAN_STEPS = 16;

    localparam logic [D_W-1:0]   EPS_Q32 = D_W'(42949673);
    localparam logic [W_W-1:0]   CAP_Q30 = W_W'(100) << 30;
    localparam logic [DIV_W-1:0] ONE_Q62 = DIV_W'(1) << 62;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic [RIX_W-1:0] REG_ROW_COUNT    = 3'd0;
    localparam logic [RIX_W-1:0] REG_COLUMN_COUNT = 3'd1;
    localparam logic [RIX_W-1:0] REG_MAP_XX       = 3'd2;
    localparam logic [RIX_W-1:0] REG_MAP_XY       = 3'd3;
    localparam logic [RIX_W-1:0] REG_MAP_X0       = 3'd4;
    localparam logic [RIX_W-1:0] REG_MAP_YX       = 3'd5;
    localparam logic [RIX_W-1:0] REG_MAP_YY       = 3'd6;
    localparam logic [RIX_W-1:0] REG_MAP_Y0       = 3'd7;

    typedef struct packed {
        logic              operation;
        logic [POS_W-1:0]  row;
        logic [POS_W-1:0]  col;
        logic signed [SMP_W-1:0] sample;
    } t_in;

    typedef struct packed {
        logic [POS_W-1:0]  out_row;
        logic [POS_W-1:0]  out_col;
        logic signed [SMP_W-1:0] resampled;
        logic              inside_res;
    } t_out;

    // One classified transaction handed from the front to the back.
    typedef struct packed {
        logic              query;
        logic [POS_W-1:0]  row;
        logic [POS_W-1:0]  col;
        logic signed [SMP_W-1:0] sample;
        logic signed [CRD_W-1:0] x;
        logic signed [CRD_W-1:0] y;
        logic [IDX_W-1:0]  xf;
        logic [IDX_W-1:0]  xc;
        logic [IDX_W-1:0]  yf;
        logic [IDX_W-1:0]  yc;
    } t_job;

endpackage

>>> design/aff_div.sv
// Shared restoring divider, one quotient bit per cycle.
// Uses aff_pkg; instantiated by aff_back.
`timescale 1ns / 1ps

module aff_div
    import aff_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic             i_short,
    input  logic [DIV_W-1:0] i_dividend,
    input  logic [DIV_W-1:0] i_divisor,
    output logic             o_done,
    output logic [W_W-1:0]   o_quotient
);

    logic             r_run, n_run;
    logic             r_done, n_done;
    logic [5:0]       r_cnt, n_cnt;
    logic [DIV_W-1:0] r_rem, n_rem;
    logic [DIV_W-1:0] r_dq, n_dq;
    logic [DIV_W-1:0] r_dsr, n_dsr;
    logic [DIV_W:0]   trial;
    logic             ge;

    // The quotient is known to fit the step count, so the partial remainder
    // starts with the top dividend bits already shifted in.
    always_comb begin
        trial = {r_rem, r_dq[DIV_W-1]};
        ge    = trial >= {1'b0, r_dsr};
        n_run  = r_run;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_dq   = r_dq;
        n_dsr  = r_dsr;
        if (i_start) begin
            n_run = 1'b1;
            n_dsr = i_divisor;
            if (i_short) begin
                n_rem = i_dividend >> MEAN_STEPS;
                n_dq  = i_dividend << (DIV_W - MEAN_STEPS);
                n_cnt = 6'(MEAN_STEPS);
            end else begin
                n_rem = i_dividend >> WGT_STEPS;
                n_dq  = i_dividend << (DIV_W - WGT_STEPS);
                n_cnt = 6'(WGT_STEPS);
            end
        end else if (r_run) begin
            n_rem = ge ? DIV_W'(trial - {1'b0, r_dsr}) : DIV_W'(trial);
            n_dq  = {r_dq[DIV_W-2:0], ge};
            n_cnt = r_cnt - 6'd1;
            if (r_cnt == 6'd1) begin
                n_run  = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_run  <= n_run;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_rem <= n_rem;
        r_dq  <= n_dq;
        r_dsr <= n_dsr;
    end

    assign o_done     = r_done;
    assign o_quotient = r_dq[W_W-1:0];

endmodule

>>> design/aff_fifo.sv
// Two-entry queue of classified transactions between front and back.
// Uses aff_pkg.
`timescale 1ns / 1ps

module aff_fifo
    import aff_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    output logic o_full,
    input  logic i_pop,
    output logic o_empty,
    output t_job o_job
);

    t_job       r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (i_pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
        if (i_push) r_mem[r_wp] <= i_job;
    end

    assign o_full  = r_cnt == 2'd2;
    assign o_empty = r_cnt == 2'd0;
    assign o_job   = r_mem[r_rp];

endmodule

>>> design/aff_front.sv
// Front end: configuration registers, input acceptance, the inverse affine
// mapping through one shared multiplier, and corner selection. Uses aff_pkg.
`timescale 1ns / 1ps

module aff_front
    import aff_pkg::*;
#(
    parameter int MAX_SIDE = MAX_SIDE_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [RIX_W-1:0] i_cfg_idx,
    input  logic [REG_W-1:0] i_cfg_data,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  t_in              i_in_data,
    output logic             o_push,
    output t_job             o_job,
    input  logic             i_full
);

    localparam logic [3:0] F_IDLE = 4'd0;
    localparam logic [3:0] F_M0   = 4'd1;
    localparam logic [3:0] F_M1   = 4'd2;
    localparam logic [3:0] F_M2   = 4'd3;
    localparam logic [3:0] F_M3   = 4'd4;
    localparam logic [3:0] F_M4   = 4'd5;
    localparam logic [3:0] F_CLP  = 4'd6;
    localparam logic [3:0] F_COR  = 4'd7;
    localparam logic [3:0] F_PUSH = 4'd8;

    localparam int LIM_I = 2 * MAX_SIDE * 65536;
    localparam logic signed [ACC_W-1:0] LIM = ACC_W'(LIM_I);

    logic [3:0]               r_st;
    logic [CNT_W-1:0]         r_rows, r_cols;
    logic signed [REG_W-1:0]  r_xx, r_xy, r_x0, r_yx, r_yy, r_y0;
    logic signed [DC_W-1:0]   r_dc2, r_dr2;
    logic signed [MUL_W-1:0]  r_prod;
    logic signed [ACC_W-1:0]  r_accx, r_accy;
    logic signed [CRD_W-1:0]  r_x, r_y;
    t_job                     r_job;

    logic [CNT_W-1:0]         eff_r, eff_c, rm1, cm1;
    logic signed [REG_W-1:0]  ma;
    logic signed [DC_W-1:0]   mb;
    logic signed [MUL_W-1:0]  mul;
    logic signed [ACC_W-1:0]  shx, shy;
    logic                     accept;

    function automatic logic [CNT_W-1:0] eff_count(input logic [CNT_W-1:0] c);
        logic [CNT_W-1:0] v;
        v = c;
        if (c == '0) v = CNT_W'(1);
        else if (32'(c) > MAX_SIDE) v = CNT_W'(MAX_SIDE);
        return v;
    endfunction

    function automatic logic signed [CRD_W-1:0] clamp_lim(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] t;
        t = v;
        if (v > LIM) t = LIM;
        else if (v < -LIM) t = -LIM;
        return CRD_W'(t);
    endfunction

    // Floor or ceiling cell of a signed Q13.16 coordinate, clamped to 0..top.
    function automatic logic [IDX_W-1:0] corner(input logic signed [CRD_W-1:0] v,
                                                input logic up,
                                                input logic [CNT_W-1:0] top);
        logic signed [CRD_W-1:0] c;
        logic [IDX_W-1:0] r;
        c = (v >>> 16) + $signed(CRD_W'(up && (v[15:0] != 16'h0)));
        if (c < 0) r = '0;
        else if (c > $signed({1'b0, top})) r = top;
        else r = IDX_W'(c);
        return r;
    endfunction

    assign eff_r  = eff_count(r_rows);
    assign eff_c  = eff_count(r_cols);
    assign rm1    = eff_r - CNT_W'(1);
    assign cm1    = eff_c - CNT_W'(1);
    assign accept = i_in_valid && (r_st == F_IDLE);

    always_comb begin
        case (r_st)
            F_M0:    begin ma = r_xx; mb = r_dc2; end
            F_M1:    begin ma = r_xy; mb = r_dr2; end
            F_M2:    begin ma = r_yx; mb = r_dc2; end
            default: begin ma = r_yy; mb = r_dr2; end
        endcase
        mul = ma * mb;
        shx = r_accx >>> 1;
        shy = r_accy >>> 1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st   <= F_IDLE;
            r_rows <= CNT_W'(128);
            r_cols <= CNT_W'(128);
            r_xx   <= REG_W'(65536);
            r_xy   <= '0;
            r_x0   <= '0;
            r_yx   <= '0;
            r_yy   <= REG_W'(65536);
            r_y0   <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_ROW_COUNT:    r_rows <= i_cfg_data[CNT_W-1:0];
                    REG_COLUMN_COUNT: r_cols <= i_cfg_data[CNT_W-1:0];
                    REG_MAP_XX:       r_xx   <= i_cfg_data;
                    REG_MAP_XY:       r_xy   <= i_cfg_data;
                    REG_MAP_X0:       r_x0   <= i_cfg_data;
                    REG_MAP_YX:       r_yx   <= i_cfg_data;
                    REG_MAP_YY:       r_yy   <= i_cfg_data;
                    REG_MAP_Y0:       r_y0   <= i_cfg_data;
                    default:          ;
                endcase
            end
            case (r_st)
                F_IDLE: begin
                    if (accept) begin
                        if (i_in_data.operation == OP_QUERY) begin
                            r_st <= F_M0;
                        end else if ({1'b0, i_in_data.row} < eff_r &&
                                     {1'b0, i_in_data.col} < eff_c) begin
                            r_st <= F_PUSH;
                        end
                    end
                end
                F_M0:    r_st <= F_M1;
                F_M1:    r_st <= F_M2;
                F_M2:    r_st <= F_M3;
                F_M3:    r_st <= F_M4;
                F_M4:    r_st <= F_CLP;
                F_CLP:   r_st <= F_COR;
                F_COR:   r_st <= F_PUSH;
                F_PUSH: begin
                    if (!i_full) r_st <= F_IDLE;
                end
                default: r_st <= F_IDLE;
            endcase
        end

        if (accept) begin
            r_dc2 <= $signed({2'b0, i_in_data.col, 1'b0}) - $signed({2'b0, cm1});
            r_dr2 <= $signed({2'b0, i_in_data.row, 1'b0}) - $signed({2'b0, rm1});
            r_job <= '{query: i_in_data.operation, row: i_in_data.row,
                       col: i_in_data.col, sample: i_in_data.sample,
                       x: '0, y: '0, xf: '0, xc: '0, yf: '0, yc: '0};
        end
        case (r_st)
            F_M0: r_prod <= mul;
            F_M1: begin
                r_accx <= ACC_W'(r_prod) + (ACC_W'(r_x0) <<< 1) +
                          $signed(ACC_W'({cm1, 16'h0}));
                r_prod <= mul;
            end
            F_M2: begin
                r_accx <= r_accx + ACC_W'(r_prod);
                r_prod <= mul;
            end
            F_M3: begin
                r_accy <= ACC_W'(r_prod) + (ACC_W'(r_y0) <<< 1) +
                          $signed(ACC_W'({rm1, 16'h0}));
                r_prod <= mul;
            end
            F_M4: r_accy <= r_accy + ACC_W'(r_prod);
            F_CLP: begin
                r_x <= clamp_lim(shx);
                r_y <= clamp_lim(shy);
            end
            F_COR: begin
                r_job.x  <= r_x;
                r_job.y  <= r_y;
                r_job.xf <= corner(r_x, 1'b0, cm1);
                r_job.xc <= corner(r_x, 1'b1, cm1);
                r_job.yf <= corner(r_y, 1'b0, rm1);
                r_job.yc <= corner(r_y, 1'b1, rm1);
            end
            default: ;
        endcase
    end

    assign o_in_stall = r_st != F_IDLE;
    assign o_push     = (r_st == F_PUSH) && !i_full;
    assign o_job      = r_job;

endmodule

>>> design/aff_back.sv
// Back end: the sample grid memory, corner weights, the weighted mean and
// the output register. Uses aff_pkg and instantiates aff_div.
`timescale 1ns / 1ps

module aff_back
    import aff_pkg::*;
#(
    parameter int MAX_SIDE = MAX_SIDE_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_empty,
    input  t_job i_job,
    output logic o_pop,
    output logic o_out_valid,
    input  logic i_out_stall,
    output t_out o_out_data
);

    localparam int DEPTH = MAX_SIDE * MAX_SIDE;
    localparam int AW    = $clog2(DEPTH);

    localparam logic [3:0] B_IDLE = 4'd0;
    localparam logic [3:0] B_RD   = 4'd1;
    localparam logic [3:0] B_SQX  = 4'd2;
    localparam logic [3:0] B_SQY  = 4'd3;
    localparam logic [3:0] B_SUM  = 4'd4;
    localparam logic [3:0] B_WGT  = 4'd5;
    localparam logic [3:0] B_WDIV = 4'd6;
    localparam logic [3:0] B_MAC  = 4'd7;
    localparam logic [3:0] B_ACC  = 4'd8;
    localparam logic [3:0] B_FIN  = 4'd9;
    localparam logic [3:0] B_FDIV = 4'd10;
    localparam logic [3:0] B_OUT  = 4'd11;

    logic [SMP_W-1:0]        r_mem [DEPTH];
    logic [3:0]              r_st;
    t_job                    r_job;
    logic [1:0]              r_k;
    logic signed [SMP_W-1:0] r_smp;
    logic [CRD_W-1:0]        r_ax, r_ay;
    logic [SQ_W-1:0]         r_sqx, r_sqy;
    logic [D_W-1:0]          r_d;
    logic [W_W-1:0]          r_w;
    logic signed [PRD_W-1:0] r_prod;
    logic signed [NUM_W-1:0] r_num;
    logic [DEN_W-1:0]        r_den;
    logic [MEAN_STEPS-1:0]   r_q;
    logic                    r_ovalid;
    t_out                    r_out;

    logic [IDX_W-1:0]        cx, cy;
    logic signed [CRD_W:0]   dx, dy;
    logic [AW-1:0]           addr;
    logic                    we, re;
    logic                    div_start, div_short, div_done;
    logic [DIV_W-1:0]        div_num, div_den;
    logic [W_W-1:0]          div_q;
    logic [NUM_W-1:0]        mag;
    logic signed [SMP_W-1:0] mean;
    logic                    out_free;

    always_comb begin
        case (r_k)
            2'd0:    begin cx = r_job.xf; cy = r_job.yf; end
            2'd1:    begin cx = r_job.xf; cy = r_job.yc; end
            2'd2:    begin cx = r_job.xc; cy = r_job.yf; end
            default: begin cx = r_job.xc; cy = r_job.yc; end
        endcase
        dx = $signed({1'b0, CRD_W'({cx, 16'h0})}) - (CRD_W+1)'(r_job.x);
        dy = $signed({1'b0, CRD_W'({cy, 16'h0})}) - (CRD_W+1)'(r_job.y);
        if (r_st == B_IDLE) begin
            addr = AW'(32'(i_job.row) * MAX_SIDE + 32'(i_job.col));
        end else begin
            addr = AW'(32'(cy) * MAX_SIDE + 32'(cx));
        end
        we = (r_st == B_IDLE) && !i_empty && !i_job.query;
        re = r_st == B_RD;

        mag = r_num[NUM_W-1] ? NUM_W'(-r_num) : NUM_W'(r_num);
        div_short = r_st == B_FIN;
        div_start = ((r_st == B_WGT) && (r_d > EPS_Q32)) || (r_st == B_FIN);
        div_num   = div_short ? DIV_W'(mag) + DIV_W'(r_den >> 1) : ONE_Q62;
        div_den   = div_short ? DIV_W'(r_den) : DIV_W'(r_d);

        // The quotient never exceeds 32768; a mean beyond the 16-bit range saturates on either sign.
        if (r_num[NUM_W-1]) begin
            mean = (r_q[MEAN_STEPS-1] && r_q[MEAN_STEPS-2:0] != '0) ?
                   SMP_W'(16'h8000) : SMP_W'(-$signed({1'b0, r_q}));
        end else begin
            mean = r_q[MEAN_STEPS-1] ? SMP_W'(16'h7FFF) : SMP_W'(r_q);
        end
        out_free = !r_ovalid || !i_out_stall;
    end

    aff_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_short    (div_short),
        .i_dividend (div_num),
        .i_divisor  (div_den),
        .o_done     (div_done),
        .o_quotient (div_q)
    );

    always_ff @(posedge i_clk) begin
        if (we) r_mem[addr] <= i_job.sample;
        if (re) r_smp <= r_mem[addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st     <= B_IDLE;
            r_ovalid <= 1'b0;
            r_k      <= '0;
        end else begin
            if (r_st == B_OUT && out_free) begin
                r_ovalid <= 1'b1;
            end else if (!i_out_stall) begin
                r_ovalid <= 1'b0;
            end
            case (r_st)
                B_IDLE: begin
                    if (!i_empty && i_job.query) begin
                        r_st <= B_RD;
                        r_k  <= '0;
                    end
                end
                B_RD:   r_st <= B_SQX;
                B_SQX:  r_st <= B_SQY;
                B_SQY:  r_st <= B_SUM;
                B_SUM:  r_st <= B_WGT;
                B_WGT:  r_st <= (r_d > EPS_Q32) ? B_WDIV : B_MAC;
                B_WDIV: if (div_done) r_st <= B_MAC;
                B_MAC:  r_st <= B_ACC;
                B_ACC: begin
                    r_k  <= r_k + 2'd1;
                    r_st <= (r_k == 2'd3) ? B_FIN : B_RD;
                end
                B_FIN:  r_st <= B_FDIV;
                B_FDIV: if (div_done) r_st <= B_OUT;
                B_OUT: begin
                    if (out_free) r_st <= B_IDLE;
                end
                default: r_st <= B_IDLE;
            endcase
        end

        if (r_st == B_IDLE && !i_empty) begin
            r_job <= i_job;
            r_num <= '0;
            r_den <= '0;
        end
        case (r_st)
            B_RD: begin
                r_ax <= dx[CRD_W] ? CRD_W'(-dx) : CRD_W'(dx);
                r_ay <= dy[CRD_W] ? CRD_W'(-dy) : CRD_W'(dy);
            end
            B_SQX:  r_sqx <= SQ_W'(r_ax) * SQ_W'(r_ax);
            B_SQY:  r_sqy <= SQ_W'(r_ay) * SQ_W'(r_ay);
            B_SUM:  r_d <= D_W'(r_sqx) + D_W'(r_sqy);
            B_WGT:  r_w <= CAP_Q30;
            B_WDIV: if (div_done) r_w <= div_q;
            B_MAC:  r_prod <= $signed({1'b0, r_w}) * r_smp;
            B_ACC: begin
                r_num <= r_num + NUM_W'(r_prod);
                r_den <= r_den + DEN_W'(r_w);
            end
            B_FDIV: if (div_done) r_q <= div_q[MEAN_STEPS-1:0];
            B_OUT: begin
                if (out_free) begin
                    r_out.out_row    <= r_job.row;
                    r_out.out_col    <= r_job.col;
                    r_out.resampled  <= mean;
                    r_out.inside_res <= mean[SMP_W-1];
                end
            end
            default: ;
        endcase
    end

    assign o_pop       = (r_st == B_IDLE) && !i_empty;
    assign o_out_valid = r_ovalid;
    assign o_out_data  = r_out;

endmodule

>>> design/affine_grid_resample.sv
// Affine grid resampler: the top level, tying front, queue and back.
// Uses aff_pkg; instantiates aff_front, aff_fifo and aff_back.
//
// Input channel (i_in_valid / o_in_stall / i_in_data) takes load and query
// transactions. A load writes one Q8.8 sample into the grid memory and gives
// no result; a load outside the configured counts is dropped. A query maps
// its destination cell through the inverse affine transform and returns one
// result on the output channel (o_out_valid / i_out_stall / o_out_data).
// Configuration registers are written through i_cfg_we, i_cfg_idx and
// i_cfg_data; the user must write them only while no transaction is in
// flight, since the block itself does not enforce this.
// A load passes the front through its idle and push states. A query also
// goes through the mapping, clamp and corner states, then through the back:
// each corner whose weight is not capped takes a 37-step pass of the shared
// divider and the final mean a 16-step pass. The divider sets the
// throughput of back-to-back queries.
// A two-entry queue lets the front accept and map the next transaction
// while the back is still busy.
// Synchronous active-low reset returns the registers to their defaults and
// empties the queue and output register; grid contents are undefined until
// loaded. While the receiver stalls, the result is held in the output
// register and the back waits; the queue then fills and stalls the input.
`timescale 1ns / 1ps

module affine_grid_resample
    import aff_pkg::*;
#(
    parameter int MAX_SIDE = MAX_SIDE_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [RIX_W-1:0] i_cfg_idx,
    input  logic [REG_W-1:0] i_cfg_data,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  t_in              i_in_data,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output t_out             o_out_data
);

    logic push, pop, full, empty;
    t_job job_in, job_out;

    aff_front #(.MAX_SIDE(MAX_SIDE)) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .o_push     (push),
        .o_job      (job_in),
        .i_full     (full)
    );

    aff_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (job_in),
        .o_full  (full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_job   (job_out)
    );

    aff_back #(.MAX_SIDE(MAX_SIDE)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_empty     (empty),
        .i_job       (job_out),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule

>>> design/aff_chk.sv
// Port-level checker for the affine grid resampler, bound to the top level.
// Uses aff_pkg.
`timescale 1ns / 1ps

module aff_chk
    import aff_pkg::*;
(
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_in_valid,
    input logic             o_in_stall,
    input t_in              i_in_data,
    input logic             o_out_valid,
    input logic             i_out_stall,
    input t_out             o_out_data
);

    a_reset_clears: assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("stalled result changed");

    a_inside_sign: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_data.inside_res == o_out_data.resampled[SMP_W-1])
        else $error("inside flag does not match sign");

    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && i_in_data.operation == OP_QUERY |=> o_in_stall)
        else $error("front took a transaction while mapping a query");

endmodule

bind affine_grid_resample aff_chk u_chk (.*);
